@@ hw/rtl/tw_pkg.sv @@
// Shared types and codes for the timing wheel scheduler.
`default_nettype none
package tw_pkg;
  localparam int unsigned FuncW = 2;
  localparam int unsigned IdW = 5;
  localparam int unsigned DelayW = 7;
  localparam int unsigned StatusW = 2;
  localparam int unsigned LeftW = 7;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD    = 2'd0,
    FUNC_CANCEL = 2'd1,
    FUNC_TICK   = 2'd2,
    FUNC_QUERY  = 2'd3
  } func_t;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_CLAMPED = 2'd1,
    ST_BUSY    = 2'd2,
    ST_IDLE    = 2'd3
  } status_t;

  typedef enum logic {
    KIND_ACK  = 1'b0,
    KIND_FIRE = 1'b1
  } kind_t;

  typedef struct packed {
    logic [FuncW-1:0]  func;
    logic [IdW-1:0]    event_id;
    logic [DelayW-1:0] delay;
  } req_t;

  typedef struct packed {
    logic              kind;
    logic [IdW-1:0]    fired_id;
    logic [StatusW-1:0] status;
    logic [LeftW-1:0]  time_left;
    logic              last;
  } rsp_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;    // latch request
    logic do_add;
    logic rm_head; // cancel: event is head of its chain
    logic walk;    // cancel: step along chain
    logic unlink;  // cancel: unlink after cursor
    logic fire;    // tick: pop head
    logic adv;     // tick: advance position
    logic emit_ack;
  } cmd_t;

  typedef struct packed {
    func_t func;
    logic  active;
    logic  head_valid;  // at target slot
    logic  is_head;
    logic  cur_has_next;
    logic  cur_next_is_id;
    logic  fire_last;   // popped event was the last of the bucket
  } sts_t;
endpackage
`default_nettype wire

@@ hw/rtl/tw_if.sv @@
// Valid/ready channel carrying one payload.
`default_nettype none
interface tw_if #(parameter type payload_t = logic) ();
  logic     valid;
  logic     ready;
  payload_t payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface
`default_nettype wire

@@ hw/rtl/tw_ctrl.sv @@
// Sequencing state machine of the timing wheel.
`default_nettype none
module tw_ctrl (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        out_free,
  output tw_pkg::cmd_t     cmd,
  input  wire tw_pkg::sts_t sts
);
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_DEC  = 5'b00010,
    S_WALK = 5'b00100,
    S_TICK = 5'b01000,
    S_DONE = 5'b10000
  } state_t;
  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= S_IDLE;
    else state <= state_next;
  end

  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd = '0;
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        if (sts.func == tw_pkg::FUNC_TICK) begin
          if (sts.head_valid) state_next = S_TICK;
          else begin
            cmd.adv = 1'b1;
            state_next = S_IDLE;
          end
        end else if (out_free) begin
          cmd.emit_ack = 1'b1;
          if (sts.func == tw_pkg::FUNC_ADD) cmd.do_add = 1'b1;
          if (sts.func == tw_pkg::FUNC_CANCEL && sts.active) begin
            if (!sts.head_valid) state_next = S_IDLE;
            else if (sts.is_head) begin
              cmd.rm_head = 1'b1;
              state_next = S_IDLE;
            end else state_next = S_WALK;
          end else state_next = S_IDLE;
        end
      end
      S_WALK: begin
        if (!sts.cur_has_next) state_next = S_IDLE;
        else if (sts.cur_next_is_id) begin
          cmd.unlink = 1'b1;
          state_next = S_IDLE;
        end else cmd.walk = 1'b1;
      end
      S_TICK: begin
        if (out_free) begin
          cmd.fire = 1'b1;
          if (sts.fire_last) begin
            cmd.adv = 1'b1;
            state_next = S_DONE;
          end
        end
      end
      S_DONE: state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end
endmodule
`default_nettype wire

@@ hw/rtl/tw_dp.sv @@
// Wheel state, chain links and result register.
`default_nettype none
module tw_dp #(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned EVENTS = 32
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire tw_pkg::req_t  req,
  input  wire tw_pkg::cmd_t  cmd,
  output tw_pkg::sts_t       sts,
  output logic               out_free,
  output logic               out_valid,
  input  wire logic          out_ready,
  output tw_pkg::rsp_t       rsp
);
  localparam int unsigned SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned SWP = SW + 1;
  localparam int unsigned EW = (EVENTS > 1) ? $clog2(EVENTS) : 1;
  localparam int unsigned DW = tw_pkg::DelayW + 1;
  localparam int unsigned CW = (SW > DW) ? SW + 1 : DW + 1;

  logic [SW-1:0] pos;
  logic [EW-1:0] link [EVENTS];
  logic [EVENTS-1:0] lvalid;
  logic [SW-1:0] eslot [EVENTS];
  logic [EVENTS-1:0] active;
  logic [EVENTS-1:0] ishead;  // event is the first of its bucket chain

  tw_pkg::req_t r;
  logic [EW-1:0] cur;
  logic [EW-1:0] rid;
  logic known;
  logic [SW-1:0] tgt;
  logic [CW-1:0] sum;
  logic clamp;
  logic [DW-1:0] dly;
  logic [SW-1:0] aslot;
  logic hv;
  logic [EW-1:0] hid;
  logic [SW:0] wrap;
  logic [SW-1:0] left;
  tw_pkg::status_t st;

  always_ff @(posedge clk) if (cmd.load) r <= req;

  assign rid   = EW'(r.event_id);
  assign known = ({{(32-tw_pkg::IdW){1'b0}}, r.event_id} < EVENTS);
  assign clamp = ({{(32-tw_pkg::DelayW){1'b0}}, r.delay} > SLOTS);
  assign dly   = clamp ? DW'(SLOTS) : {1'b0, r.delay};
  assign sum   = CW'(pos) + CW'(dly);
  // Sum stays below 2*SLOTS.
  always_comb begin
    logic [CW-1:0] s;
    s = sum;
    if (s >= CW'(SLOTS)) s = s - CW'(SLOTS);
    if (s >= CW'(SLOTS)) s = s - CW'(SLOTS);
    tgt = s[SW-1:0];
  end
  assign aslot = (r.func == tw_pkg::FUNC_ADD) ? tgt :
                 (r.func == tw_pkg::FUNC_TICK) ? pos : eslot[rid];

  // Bucket head: the one event flagged as head whose slot matches.
  always_comb begin
    hv = 1'b0;
    hid = '0;
    for (int unsigned e = 0; e < EVENTS; e++) begin
      if (ishead[e] && eslot[e] == aslot) begin
        hv = 1'b1;
        hid = EW'(e);
      end
    end
  end

  assign wrap = {1'b0, eslot[rid]} + SWP'(SLOTS) - {1'b0, pos};
  assign left = (eslot[rid] >= pos) ? eslot[rid] - pos : wrap[SW-1:0];

  always_comb begin
    sts.func = tw_pkg::func_t'(r.func);
    sts.active = known && active[rid];
    sts.head_valid = hv;
    sts.is_head = (hid == rid);
    sts.cur_has_next = lvalid[cur];
    sts.cur_next_is_id = (link[cur] == rid);
    sts.fire_last = !lvalid[hid];
  end

  always_comb begin
    st = tw_pkg::ST_OK;
    unique case (r.func)
      tw_pkg::FUNC_ADD:
        if (!known || active[rid]) st = tw_pkg::ST_BUSY;
        else if (clamp) st = tw_pkg::ST_CLAMPED;
      tw_pkg::FUNC_CANCEL, tw_pkg::FUNC_QUERY:
        if (!sts.active) st = tw_pkg::ST_IDLE;
      default: st = tw_pkg::ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos <= '0;
      ishead <= '0;
      lvalid <= '0;
      active <= '0;
    end else begin
      if (cmd.do_add && known && !active[rid]) begin
        lvalid[rid] <= hv;
        link[rid] <= hid;
        if (hv) ishead[hid] <= 1'b0;
        ishead[rid] <= 1'b1;
        eslot[rid] <= tgt;
        active[rid] <= 1'b1;
      end
      if (cmd.emit_ack && r.func == tw_pkg::FUNC_CANCEL && sts.active) begin
        active[rid] <= 1'b0;
        cur <= hid;
      end
      if (cmd.rm_head) begin
        ishead[rid] <= 1'b0;
        if (lvalid[rid]) ishead[link[rid]] <= 1'b1;
        lvalid[rid] <= 1'b0;
      end
      if (cmd.walk) cur <= link[cur];
      if (cmd.unlink) begin
        lvalid[cur] <= lvalid[rid];
        link[cur] <= link[rid];
        lvalid[rid] <= 1'b0;
      end
      if (cmd.fire) begin
        ishead[hid] <= 1'b0;
        if (lvalid[hid]) ishead[link[hid]] <= 1'b1;
        lvalid[hid] <= 1'b0;
        active[hid] <= 1'b0;
      end
      if (cmd.adv) pos <= (pos == SW'(SLOTS - 1)) ? '0 : pos + 1'b1;
    end
  end

  // Result register.
  assign out_free = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (cmd.emit_ack || cmd.fire) out_valid <= 1'b1;
    else if (out_ready) out_valid <= 1'b0;
  end
  always_ff @(posedge clk) begin
    if (cmd.fire) begin
      rsp.kind <= tw_pkg::KIND_FIRE;
      rsp.fired_id <= tw_pkg::IdW'(hid);
      rsp.status <= tw_pkg::ST_OK;
      rsp.time_left <= '0;
      rsp.last <= !lvalid[hid];
    end else if (cmd.emit_ack) begin
      rsp.kind <= tw_pkg::KIND_ACK;
      rsp.fired_id <= r.event_id;
      rsp.status <= st;
      rsp.last <= 1'b1;
      if (r.func == tw_pkg::FUNC_QUERY)
        rsp.time_left <= sts.active ? tw_pkg::LeftW'(left) : tw_pkg::LeftW'(SLOTS + 1);
      else rsp.time_left <= '0;
    end
  end
endmodule
`default_nettype wire

@@ hw/rtl/timing_wheel_event_scheduler.sv @@
// Top level of the single-level timing wheel event scheduler.
// Requests arrive on req (func, event_id, delay); results leave on rsp.
// Add, cancel and query give one acknowledge; a tick gives one fired result
// per event in the current bucket, in chain order, last set on the final
// one, and none if the bucket is empty.
// Add and query are decoded, then answered through the result register; a cancel
// walks the bucket chain one link a cycle, down to the event's place in
// its chain; a tick pops its events one by one, then advances the position.
// One request is worked on at a time; req is ready only when idle.
// Reset clears the position and every head, link-valid and active flag at once.
// A stalled result holds in the output register and the sequencer waits.
`default_nettype none
module timing_wheel_event_scheduler #(
  parameter int unsigned SLOTS  = 64,
  parameter int unsigned EVENTS = 32
) (
  input wire logic clk,
  input wire logic rst,
  tw_if.sink       req,
  tw_if.source     rsp
);
  tw_pkg::cmd_t cmd;
  tw_pkg::sts_t sts;
  logic out_free;

  tw_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(req.valid), .in_ready(req.ready),
    .out_free(out_free), .cmd(cmd), .sts(sts)
  );

  tw_dp #(.SLOTS(SLOTS), .EVENTS(EVENTS)) u_dp (
    .clk(clk), .rst(rst), .req(req.payload), .cmd(cmd), .sts(sts),
    .out_free(out_free), .out_valid(rsp.valid), .out_ready(rsp.ready),
    .rsp(rsp.payload)
  );
endmodule
`default_nettype wire

@@ tb/sv/tb.sv @@
// Testbench for the timing wheel scheduler: directed and random requests, checked by a model.
module tb;
  localparam int Slots = 64;
  localparam int Events = 32;
  localparam int CycleLimit = 4000000;

  logic clk = 1'b0;
  logic rst = 1'b1;
  always #5 clk = ~clk;

  tw_if #(.payload_t(tw_pkg::req_t)) req ();
  tw_if #(.payload_t(tw_pkg::rsp_t)) rsp ();

  timing_wheel_event_scheduler u_dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  // Wheel model state
  int unsigned wheel_pos;
  int          bucket_chain[Slots][$]; // head at index 0
  bit          ev_active[Events];
  int unsigned ev_slot[Events];

  tw_pkg::rsp_t expected_rsps[$];
  int   fail_count = 0;
  bit   hold_off = 1'b0;
  int unsigned cycles = 0;

  function automatic tw_pkg::rsp_t make_rsp(tw_pkg::kind_t k, int unsigned id,
                                            tw_pkg::status_t s, int unsigned left,
                                            logic lst);
    tw_pkg::rsp_t r;
    r.kind = k;
    r.fired_id = tw_pkg::IdW'(id);
    r.status = s;
    r.time_left = tw_pkg::LeftW'(left);
    r.last = lst;
    return r;
  endfunction

  task automatic predict_wheel(tw_pkg::req_t q);
    int unsigned id;
    int unsigned d;
    int unsigned pos;
    int n;
    bit act;
    tw_pkg::status_t st;
    id = 32'(q.event_id);
    act = (id < Events) && ev_active[id];
    case (tw_pkg::func_t'(q.func))
      tw_pkg::FUNC_ADD: begin
        if (id >= Events || act) begin
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_ACK, id, tw_pkg::ST_BUSY, 0, 1'b1));
        end else begin
          d = 32'(q.delay);
          st = tw_pkg::ST_OK;
          if (d > Slots) begin
            d = Slots;
            st = tw_pkg::ST_CLAMPED;
          end
          pos = (wheel_pos + d) % Slots;
          bucket_chain[pos].push_front(id);
          ev_slot[id] = pos;
          ev_active[id] = 1'b1;
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_ACK, id, st, 0, 1'b1));
        end
      end
      tw_pkg::FUNC_CANCEL: begin
        if (!act) begin
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_ACK, id, tw_pkg::ST_IDLE, 0, 1'b1));
        end else begin
          pos = ev_slot[id];
          for (int i = 0; i < bucket_chain[pos].size(); i++) begin
            if (bucket_chain[pos][i] == id) begin
              bucket_chain[pos].delete(i);
              break;
            end
          end
          ev_active[id] = 1'b0;
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_ACK, id, tw_pkg::ST_OK, 0, 1'b1));
        end
      end
      tw_pkg::FUNC_QUERY: begin
        if (!act)
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_ACK, id, tw_pkg::ST_IDLE,
                                           Slots + 1, 1'b1));
        else
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_ACK, id, tw_pkg::ST_OK,
                                           (ev_slot[id] + Slots - wheel_pos) % Slots,
                                           1'b1));
      end
      default: begin
        n = bucket_chain[wheel_pos].size();
        for (int i = 0; i < n; i++) begin
          id = bucket_chain[wheel_pos][i];
          ev_active[id] = 1'b0;
          expected_rsps.push_back(make_rsp(tw_pkg::KIND_FIRE, id, tw_pkg::ST_OK, 0,
                                           i == n - 1));
        end
        bucket_chain[wheel_pos].delete();
        wheel_pos = (wheel_pos + 1) % Slots;
      end
    endcase
  endtask

  function automatic int rand_gap();
    if ($urandom_range(0, 2) == 0) return 0;
    if ($urandom_range(0, 19) == 0) return $urandom_range(10, 40);
    return $urandom_range(0, 3);
  endfunction

  bit no_gaps = 1'b0;

  // Valid stays up between back-to-back requests and drops only for a gap.
  task automatic send_request(tw_pkg::func_t f, int unsigned id, int unsigned d);
    tw_pkg::req_t q;
    int gap;
    q.func = f;
    q.event_id = tw_pkg::IdW'(id);
    q.delay = tw_pkg::DelayW'(d);
    gap = no_gaps ? 0 : rand_gap();
    if (gap > 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid <= 1'b1;
    req.payload <= q;
    @(posedge clk);
    while (!req.ready) @(posedge clk);
    predict_wheel(q);
  endtask

  // Result side: random stalls, or a long hold-off when asked.
  initial begin
    int stall;
    rsp.ready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        rsp.ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_off = 1'b0;
      end
      stall = no_gaps ? 0 : rand_gap();
      if (stall > 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      rsp.ready <= 1'b1;
      @(posedge clk);
    end
  end

  always @(posedge clk) begin
    tw_pkg::rsp_t exp_r;
    cycles <= cycles + 1;
    if (!rst && rsp.valid && rsp.ready) begin
      if (expected_rsps.size() == 0) begin
        $error("unexpected result %p", rsp.payload);
        fail_count++;
      end else begin
        exp_r = expected_rsps.pop_front();
        if (rsp.payload.kind !== exp_r.kind) begin
          $error("kind: expected %0d actual %0d", exp_r.kind, rsp.payload.kind);
          fail_count++;
        end
        if (rsp.payload.fired_id !== exp_r.fired_id) begin
          $error("fired_id: expected %0d actual %0d", exp_r.fired_id, rsp.payload.fired_id);
          fail_count++;
        end
        if (rsp.payload.status !== exp_r.status) begin
          $error("status: expected %0d actual %0d", exp_r.status, rsp.payload.status);
          fail_count++;
        end
        if (rsp.payload.time_left !== exp_r.time_left) begin
          $error("time_left: expected %0d actual %0d", exp_r.time_left,
                 rsp.payload.time_left);
          fail_count++;
        end
        if (rsp.payload.last !== exp_r.last) begin
          $error("last: expected %0d actual %0d", exp_r.last, rsp.payload.last);
          fail_count++;
        end
      end
    end
    if (cycles > CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  task automatic test_directed();
    send_request(tw_pkg::FUNC_QUERY, 0, 0);
    send_request(tw_pkg::FUNC_CANCEL, 31, 0);
    send_request(tw_pkg::FUNC_ADD, 0, 0);        // lands in current bucket
    send_request(tw_pkg::FUNC_ADD, 1, Slots);    // also current bucket
    send_request(tw_pkg::FUNC_ADD, 2, 127);      // clamped
    send_request(tw_pkg::FUNC_ADD, 2, 5);        // busy
    send_request(tw_pkg::FUNC_ADD, 31, 1);
    send_request(tw_pkg::FUNC_ADD, 3, 1);
    send_request(tw_pkg::FUNC_ADD, 4, 63);
    send_request(tw_pkg::FUNC_QUERY, 4, 0);
    send_request(tw_pkg::FUNC_QUERY, 0, 0);
    send_request(tw_pkg::FUNC_CANCEL, 1, 0);     // middle of chain
    send_request(tw_pkg::FUNC_CANCEL, 1, 0);     // now idle
    send_request(tw_pkg::FUNC_TICK, 0, 0);
    send_request(tw_pkg::FUNC_QUERY, 31, 0);
    send_request(tw_pkg::FUNC_CANCEL, 3, 0);     // head of chain
    send_request(tw_pkg::FUNC_TICK, 0, 0);
    send_request(tw_pkg::FUNC_TICK, 0, 0);       // empty bucket
    send_request(tw_pkg::FUNC_QUERY, 4, 42);
    send_request(tw_pkg::FUNC_ADD, 21, 64);
    send_request(tw_pkg::FUNC_ADD, 10, 85);
  endtask

  // Many events in a few buckets, so ticks fire long chains.
  task automatic test_random();
    int r;
    for (int i = 0; i < 440; i++) begin
      r = $urandom_range(0, 99);
      if (r < 40)
        send_request(tw_pkg::FUNC_ADD, $urandom_range(0, 31),
                     ($urandom_range(0, 3) == 0) ? $urandom_range(0, 127)
                                                 : $urandom_range(0, 3));
      else if (r < 55)
        send_request(tw_pkg::FUNC_CANCEL, $urandom_range(0, 31), $urandom_range(0, 127));
      else if (r < 80)
        send_request(tw_pkg::FUNC_TICK, $urandom_range(0, 31), $urandom_range(0, 127));
      else
        send_request(tw_pkg::FUNC_QUERY, $urandom_range(0, 31), $urandom_range(0, 127));
    end
  endtask

  task automatic test_backpressure();
    hold_off = 1'b1;
    no_gaps = 1'b1;
    for (int i = 0; i < 12; i++) send_request(tw_pkg::FUNC_QUERY, i, 0);
    no_gaps = 1'b0;
  endtask

  initial begin
    req.valid = 1'b0;
    req.payload = '0;
    wheel_pos = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_backpressure();
    test_random();
    req.valid <= 1'b0;
    while (expected_rsps.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (fail_count == 0 && expected_rsps.size() == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end
endmodule
